// ===== rtl/sdf_pkg.sv =====
// ----------------------------------------------------------------------------
// sdf_pkg
// Shared types and constants of the signed decimal formatter: request and
// character payloads, the control word handed to the character sequencer,
// the state encoding and the ASCII codes.
// ----------------------------------------------------------------------------
package sdf_pkg;

	localparam int VALUE_WIDTH = 16;
	localparam int PAD_W       = 4;
	localparam int CHAR_W      = 8;
	localparam int DIGIT_W     = 4;
	// Enough decimal digits for the magnitude 2**(VALUE_WIDTH-1)
	localparam int BCD_DIGITS  = (3 * VALUE_WIDTH + 9) / 10;

	localparam logic [CHAR_W-1:0]  CH_ZERO   = 8'h30;
	localparam logic [CHAR_W-1:0]  CH_MINUS  = 8'h2D;
	// Shift-and-add-3: a digit at or above half the radix is corrected
	localparam logic [DIGIT_W-1:0] ADJ_LIMIT = 4'd5;
	localparam logic [DIGIT_W-1:0] ADJ_ADD   = 4'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_EMIT
	} fmt_state_t;

	typedef struct packed {
		logic signed [VALUE_WIDTH-1:0] value;
		logic [PAD_W-1:0]              min_digits;
	} num_t;

	typedef struct packed {
		logic [CHAR_W-1:0] ascii_char;
		logic              last;
	} chr_t;

	typedef struct packed {
		logic             neg;
		logic             zero;
		logic [PAD_W-1:0] pad;
	} fmt_ctl_t;

endpackage

// ===== rtl/signed_decimal_formatter.sv =====
// A request is taken only in the idle state: the next number is accepted once the digit scan
//   of the previous one has finished, so conversions do not overlap.
// The bit-serial BCD conversion and the one-position-per-cycle digit scan set the pace; output
//   stalls hold the scan. The last character may wait in the output register meanwhile.
// Reset: arst_n clears the FSM, counters and valid flags at once; no clearing pass. Data and
//   ctl_q registers are not reset.
// ----------------------------------------------------------------------------
// signed_decimal_formatter
// Formats a signed integer as ASCII decimal text, most significant character
// first, with optional zero padding and a flag on the final character.
// ----------------------------------------------------------------------------
module signed_decimal_formatter #(
	parameter int MAX_DIGITS = 10
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          num_valid,
	output logic          num_stall,
	input  sdf_pkg::num_t num,
	output logic          chr_valid,
	input  logic          chr_stall,
	output sdf_pkg::chr_t chr
);
	import sdf_pkg::*;

	// Digit positions scanned per number: wide enough for both the
	// largest magnitude and the largest padding request.
	localparam int POS_DIGITS = (MAX_DIGITS > BCD_DIGITS) ? MAX_DIGITS : BCD_DIGITS;
	localparam int BCD_W      = BCD_DIGITS * DIGIT_W;

	fmt_state_t             state_q;
	fmt_state_t             state_nxt;
	fmt_ctl_t               ctl_q;

	logic                   accept;
	logic                   start;
	logic                   load;
	logic                   conv_done;
	logic                   emit_done;
	logic [VALUE_WIDTH-1:0] val_u;
	logic [VALUE_WIDTH-1:0] mag;
	logic [PAD_W-1:0]       pad_sat;
	logic [BCD_W-1:0]       bcd;

	// Magnitude as an unsigned word: the most negative value negates to
	// exactly 2**(VALUE_WIDTH-1), which still fits.
	always_comb begin
		val_u   = num.value;
		mag     = val_u[VALUE_WIDTH-1] ? (VALUE_WIDTH'(0) - val_u) : val_u;
		pad_sat = (num.min_digits > PAD_W'(MAX_DIGITS)) ? PAD_W'(MAX_DIGITS)
		                                                : num.min_digits;
		accept  = num_valid && !num_stall;
	end

	// Next state: convert, then emit, then take the next request
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (num_valid) begin
					state_nxt = ST_CONV;
				end
			end
			ST_CONV: begin
				if (conv_done) begin
					state_nxt = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (emit_done) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// State outputs: stall requests while busy, kick the two units
	always_comb begin
		num_stall = 1'b1;
		start     = 1'b0;
		load      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				num_stall = 1'b0;
				start     = num_valid;
			end
			ST_CONV: begin
				load = conv_done;
			end
			ST_EMIT: begin
				num_stall = 1'b1;
			end
			default: begin
				num_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Hold sign, zero flag and saturated padding for the sequencer
	always_ff @(posedge clk) begin
		if (accept) begin
			ctl_q.neg  <= val_u[VALUE_WIDTH-1];
			ctl_q.zero <= (val_u == '0);
			ctl_q.pad  <= pad_sat;
		end
	end

	sdf_dabble u_dabble (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.mag    (mag),
		.done   (conv_done),
		.bcd    (bcd)
	);

	sdf_emit #(
		.POS_DIGITS (POS_DIGITS)
	) u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.ctl       (ctl_q),
		.bcd       (bcd),
		.chr_stall (chr_stall),
		.done      (emit_done),
		.chr_valid (chr_valid),
		.chr       (chr)
	);

`ifndef SYNTHESIS
	a_conv_in_conv: assert property (@(posedge clk) disable iff (!arst_n)
		conv_done |-> (state_q == ST_CONV))
		else $error("conversion finished outside the convert state");

	a_emit_in_emit: assert property (@(posedge clk) disable iff (!arst_n)
		emit_done |-> (state_q == ST_EMIT))
		else $error("character scan finished outside the emit state");

	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(chr_valid && (chr.ascii_char == CH_MINUS)) |-> !chr.last)
		else $error("minus sign flagged as final character");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_CONV) && num_stall)
		else $error("accepted request did not start a conversion");
`endif

endmodule

// ===== rtl/sdf_dabble.sv =====
// ----------------------------------------------------------------------------
// sdf_dabble
// Bit-serial binary to BCD converter: shifts the magnitude in one bit per
// cycle, most significant first, with a per-digit add-3 correction.
// ----------------------------------------------------------------------------
module sdf_dabble (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          start,
	input  logic [sdf_pkg::VALUE_WIDTH-1:0]               mag,
	output logic                                          done,
	output logic [sdf_pkg::BCD_DIGITS*sdf_pkg::DIGIT_W-1:0] bcd
);
	import sdf_pkg::*;

	localparam int CNT_W = $clog2(VALUE_WIDTH + 1);
	localparam int BCD_W = BCD_DIGITS * DIGIT_W;

	logic [VALUE_WIDTH-1:0] bin_q;
	logic [BCD_W-1:0]       bcd_q;
	logic [BCD_W-1:0]       bcd_adj;
	logic [CNT_W-1:0]       cnt_q;
	logic                   done_q;

	always_comb begin
		for (int i = 0; i < BCD_DIGITS; i++) begin
			if (bcd_q[i*DIGIT_W +: DIGIT_W] >= ADJ_LIMIT) begin
				bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_q[i*DIGIT_W +: DIGIT_W] + ADJ_ADD;
			end else begin
				bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_q[i*DIGIT_W +: DIGIT_W];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == CNT_W'(1));
			if (start) begin
				cnt_q <= CNT_W'(VALUE_WIDTH);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			bin_q <= mag;
			bcd_q <= '0;
		end else if (cnt_q != '0) begin
			bcd_q <= {bcd_adj[BCD_W-2:0], bin_q[VALUE_WIDTH-1]};
			bin_q <= {bin_q[VALUE_WIDTH-2:0], 1'b0};
		end
	end

	assign done = done_q;
	assign bcd  = bcd_q;

endmodule

// ===== rtl/sdf_emit.sv =====
// ----------------------------------------------------------------------------
// sdf_emit
// Character sequencer: sends the minus sign, then walks the digit positions
// from the top one per cycle unless the output stalls, dropping leading zeros
// outside the padding, into a registered output stage.
// ----------------------------------------------------------------------------
module sdf_emit #(
	parameter int POS_DIGITS = 10
) (
	input  logic                                            clk,
	input  logic                                            arst_n,
	input  logic                                            load,
	input  sdf_pkg::fmt_ctl_t                               ctl,
	input  logic [sdf_pkg::BCD_DIGITS*sdf_pkg::DIGIT_W-1:0] bcd,
	input  logic                                            chr_stall,
	output logic                                            done,
	output logic                                            chr_valid,
	output sdf_pkg::chr_t                                   chr
);
	import sdf_pkg::*;

	localparam int POS_W  = $clog2(POS_DIGITS);
	localparam int DIG_AW = POS_DIGITS * DIGIT_W;

	logic [DIG_AW-1:0]  dig_q;
	logic [POS_W-1:0]   pos_q;
	logic [PAD_W-1:0]   pad_q;
	logic               active_q;
	logic               sign_q;
	logic               started_q;
	logic               chr_valid_q;
	chr_t               chr_q;

	logic [DIGIT_W-1:0] top_dig;
	logic               pos_last;
	logic               below_pad;
	logic               show;
	logic               out_free;
	logic               step;
	logic               put;
	logic [CHAR_W-1:0]  char_nxt;
	logic               last_nxt;

	always_comb begin
		top_dig   = dig_q[DIG_AW-1 -: DIGIT_W];
		pos_last  = (pos_q == '0);
		below_pad = ({{PAD_W{1'b0}}, pos_q} < {{POS_W{1'b0}}, pad_q});
		show      = started_q || (top_dig != '0) || below_pad || pos_last;
		out_free  = !chr_valid_q || !chr_stall;
		step      = active_q && out_free;
		put       = step && (sign_q || show);
		char_nxt  = sign_q ? CH_MINUS : (CH_ZERO + CHAR_W'(top_dig));
		last_nxt  = !sign_q && pos_last;
		done      = step && !sign_q && pos_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			sign_q      <= 1'b0;
			started_q   <= 1'b0;
			pos_q       <= '0;
			chr_valid_q <= 1'b0;
		end else begin
			if (load) begin
				active_q  <= 1'b1;
				sign_q    <= ctl.neg;
				started_q <= 1'b0;
				pos_q     <= POS_W'(POS_DIGITS - 1);
			end else if (step) begin
				if (sign_q) begin
					sign_q <= 1'b0;
				end else begin
					started_q <= started_q || show;
					pos_q     <= pos_q - 1'b1;
					if (pos_last) begin
						active_q <= 1'b0;
					end
				end
			end
			if (out_free) begin
				chr_valid_q <= put;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			dig_q <= DIG_AW'(bcd);
			pad_q <= ctl.zero ? '0 : ctl.pad;
		end else if (step && !sign_q) begin
			dig_q <= {dig_q[DIG_AW-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
		end
		if (put) begin
			chr_q.ascii_char <= char_nxt;
			chr_q.last       <= last_nxt;
		end
	end

	assign chr_valid = chr_valid_q;
	assign chr       = chr_q;

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the signed decimal formatter. Numbers are fed
// through the request channel. A local formatting function turns each
// accepted request into its expected characters. Every character that leaves
// the block is checked against the oldest one still owed. Both channels see
// random gaps and stalls, with calm stretches in between.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sdf_pkg::*;

	localparam int MAX_DIGITS   = 10;
	localparam int RANDOM_NUMS  = 380;
	// Longest legal run is well under this; it only catches a hung block
	localparam int LIMIT        = 1000000;
	// Room for a stray character to surface once nothing is owed
	localparam int DRAIN_CYCLES = 3 * (VALUE_WIDTH + MAX_DIGITS + 4);

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic num_valid = 1'b0;
	logic num_stall;
	num_t num = '0;
	logic chr_valid;
	logic chr_stall = 1'b0;
	chr_t chr;

	num_t pend_nums [$];   // requests not yet offered to the block
	chr_t want_chars [$];  // characters owed by the block, oldest first
	int bad_chars = 0;
	int cycle_cnt = 0;
	int unsigned send_gap = 0;
	int unsigned stall_len = 0;
	logic drain = 1'b0;

	signed_decimal_formatter #(
		.MAX_DIGITS(MAX_DIGITS)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.num_valid (num_valid),
		.num_stall (num_stall),
		.num       (num),
		.chr_valid (chr_valid),
		.chr_stall (chr_stall),
		.chr       (chr)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
	end

	// Mostly short pauses, now and then a long one
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		else
			return $urandom_range(20, 60);
	endfunction

	// Expected text of one number: sign, zero padding, then the digits
	function automatic void format_number(num_t n);
		logic [VALUE_WIDTH:0] mag;
		logic [3:0]           digs [0:7];
		logic                 neg;
		int                   pad;
		int                   ndig;
		int                   total;
		int                   lead;
		chr_t                 c;
		neg = n.value[VALUE_WIDTH-1];
		// Form the magnitude one bit wider so the most negative value fits
		mag = neg ? ({1'b1, {VALUE_WIDTH{1'b0}}} - {1'b0, n.value}) : {1'b0, n.value};
		pad = (n.min_digits > MAX_DIGITS) ? MAX_DIGITS : int'(n.min_digits);
		// A zero value is a lone '0', padding or not
		if (mag == '0) begin
			c.ascii_char = CH_ZERO;
			c.last = 1'b1;
			want_chars.push_back(c);
			return;
		end
		ndig = 0;
		while (mag != '0) begin
			digs[ndig] = 4'(mag % 10);
			mag = mag / 10;
			ndig++;
		end
		// The sign never counts toward the minimum digit count
		total = (ndig > pad ? ndig : pad) + (neg ? 1 : 0);
		lead = total - ndig;
		for (int i = 0; i < total; i++) begin
			if (neg && i == 0)
				c.ascii_char = CH_MINUS;
			else if (i < lead)
				c.ascii_char = CH_ZERO;
			else
				c.ascii_char = CH_ZERO + digs[total-1-i];
			c.last = (i == total - 1);
			want_chars.push_back(c);
		end
	endfunction

	task automatic queue_num(int v, int m);
		num_t n;
		n.value = 16'(v);
		n.min_digits = 4'(m);
		pend_nums.push_back(n);
	endtask

	// Request driver: predict on acceptance, hold while stalled, otherwise
	// advance to the next pending number after a random pause.
	always @(posedge clk) begin
		if (arst_n) begin
			if (num_valid && !num_stall)
				format_number(num);
			if (!(num_valid && num_stall)) begin
				// Pick the pause after each accepted request; skip it in calm stretches
				if (num_valid)
					send_gap = (cycle_cnt[10:8] == 3'd0) ? 0 : pick_gap();
				if (send_gap != 0 || pend_nums.size() == 0) begin
					if (send_gap != 0)
						send_gap--;
					num_valid <= 1'b0;
				end else begin
					num_valid <= 1'b1;
					num <= pend_nums.pop_front();
				end
			end
		end
	end

	// Character monitor and stall driver
	always @(posedge clk) begin
		chr_t want;
		if (arst_n) begin
			if (chr_valid && !chr_stall) begin
				if (want_chars.size() == 0) begin
					$display("%0t: unexpected char actual=%h last=%b",
						$time, chr.ascii_char, chr.last);
					bad_chars++;
				end else begin
					want = want_chars.pop_front();
					if (chr.ascii_char !== want.ascii_char) begin
						$display("%0t: ascii_char expected=%h actual=%h",
							$time, want.ascii_char, chr.ascii_char);
						bad_chars++;
					end
					if (chr.last !== want.last) begin
						$display("%0t: last expected=%b actual=%b",
							$time, want.last, chr.last);
						bad_chars++;
					end
				end
			end
			// Stall in random bursts; drop stalls in calm stretches and at the end
			if (stall_len == 0 && !drain && cycle_cnt[10:8] != 3'd4)
				stall_len = pick_gap();
			if (stall_len != 0 && !drain) begin
				stall_len--;
				chr_stall <= 1'b1;
			end else begin
				chr_stall <= 1'b0;
			end
		end
	end

	initial begin
		int unsigned r;
		int          v;
		int          e;

		// Directed: field extremes, zero, saturated padding, sign handling
		queue_num(0, 0);
		queue_num(0, 15);           // zero ignores padding
		queue_num(0, 10);
		queue_num(32767, 0);
		queue_num(32767, 10);
		queue_num(-32768, 0);       // most negative value
		queue_num(-32768, 15);      // padding saturates at the maximum
		queue_num(-1, 0);
		queue_num(-1, 3);
		queue_num(1, 10);
		queue_num(1, 11);
		queue_num(9, 1);
		queue_num(10, 2);
		queue_num(-10, 2);          // minimum equals natural length
		queue_num(12345, 5);
		queue_num(12345, 4);        // minimum below natural length
		queue_num(-5, 1);
		queue_num(100, 15);
		queue_num(-100, 12);
		queue_num(16'h5555, 7);
		queue_num(16'hAAAA, 8);
		queue_num(9999, 6);
		queue_num(-10000, 9);

		// Random: mix full-range, small and boundary values
		for (int k = 0; k < RANDOM_NUMS; k++) begin
			r = $urandom_range(0, 99);
			if (r < 40) begin
				v = int'($urandom);
			end else if (r < 60) begin
				v = int'($urandom_range(0, 198)) - 99;
			end else if (r < 72) begin
				e = 10 ** $urandom_range(0, 4);
				case ($urandom_range(0, 5))
					0: v = e;
					1: v = e - 1;
					2: v = -e;
					3: v = 1 - e;
					4: v = 32767;
					default: v = -32768;
				endcase
			end else begin
				v = int'($urandom_range(0, 19998)) - 9999;
			end
			queue_num(v, $urandom_range(0, 15));
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Wait until every request is taken and every character has come back
		while (pend_nums.size() != 0 || num_valid || want_chars.size() != 0)
			@(posedge clk);
		drain <= 1'b1;
		repeat (DRAIN_CYCLES) @(posedge clk);

		// Characters still owed at the end count as missing
		if (want_chars.size() != 0)
			$display("%0t: missing chars expected=%0d actual=0",
				$time, want_chars.size());

		if (bad_chars == 0 && want_chars.size() == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

	initial begin
		wait (cycle_cnt >= LIMIT);
		$display("tb: errors");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/sdf_pkg.sv
rtl/sdf_dabble.sv
rtl/sdf_emit.sv
rtl/signed_decimal_formatter.sv
tb/tb.sv
